// ===== sv/opc_pkg.sv =====
// Package for the online prefix palindrome check.
// Types and constants for the sequencer and the mod-103 unit.
// No dependencies.
package opc_pkg;

	localparam logic [7:0] MOD       = 8'd103;
	localparam logic [7:0] RADIX_RED = 8'(256 % 103);
	localparam logic [9:0] RECIP     = 10'd636;
	localparam int         RECIP_SH  = 16;

	typedef struct packed {
		logic       go;
		logic [6:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} mod_req_t;

endpackage

// ===== sv/opc_sym_if.sv =====
// Input channel: one byte request with its start flag.
// No dependencies.
interface opc_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       start_req;

	modport source (output valid, symbol, start_req, input ready);
	modport sink   (input valid, symbol, start_req, output ready);
endinterface

// ===== sv/opc_res_if.sv =====
// Output channel: one result request per accepted byte.
// No dependencies.
interface opc_res_if;
	logic valid;
	logic ready;
	logic is_palindrome;
	logic overflow;

	modport source (output valid, is_palindrome, overflow, input ready);
	modport sink   (input valid, is_palindrome, overflow, output ready);
endinterface

// ===== sv/opc_mod_unit.sv =====
// Shared unit: (a * b + c) mod 103, three register stages.
// Uses opc_pkg (mod_req_t, MOD, RECIP, RECIP_SH).
module opc_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  opc_pkg::mod_req_t req,
	output logic              done,
	output logic [6:0]        res
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [14:0] v_s1, v_s2;
	logic [7:0]  q_s2;
	logic [6:0]  res_s3;
	logic [24:0] qp;
	logic [15:0] qm;
	logic [15:0] r16;
	logic [7:0]  r8;

	// quotient estimate is exact or one low
	assign qp  = {10'd0, v_s1} * {15'd0, opc_pkg::RECIP};
	assign qm  = {8'd0, q_s2} * {8'd0, opc_pkg::MOD};
	assign r16 = {1'b0, v_s2} - qm;
	assign r8  = r16[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1   <= {8'd0, req.a} * {7'd0, req.b} + {7'd0, req.c};
		v_s2   <= v_s1;
		q_s2   <= qp[opc_pkg::RECIP_SH +: 8];
		res_s3 <= (r8 >= opc_pkg::MOD) ? 7'(r8 - opc_pkg::MOD) : r8[6:0];
	end

	assign done = vld_s3;
	assign res  = res_s3;

endmodule

// ===== sv/opc_char_store.sv =====
// Byte buffer: one write port, two registered read ports.
// No dependencies.
module opc_char_store #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [7:0]        wd,
	input  logic [ADDR_W-1:0] ra,
	input  logic [ADDR_W-1:0] rb,
	output logic [7:0]        rd_a,
	output logic [7:0]        rd_b
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a <= mem[ra];
		rd_b <= mem[rb];
	end

endmodule

// ===== sv/online_prefix_palindrome_check.sv =====
// Top level of the online prefix palindrome check: sequencer, hashes, result register.
// Uses opc_pkg, opc_sym_if, opc_res_if, opc_mod_unit, opc_char_store.
//
//   channel  dir  payload                    role
//   sym      in   symbol[7:0], start_req     one byte of the stream
//   res      out  is_palindrome, overflow    one result per byte
//
// A dropped byte (buffer full) goes straight to the result and a first byte skips the hashes;
// otherwise 3 or 4 hash steps run on the shared mod-103 unit.
// When the hashes agree the buffer walk compares each mirrored pair (up to MAX_LEN/2).
// sym.ready is high only while idle; an unread result holds the next one in its last cycle.
// Reset clears the string state; the buffer needs no clearing.
module online_prefix_palindrome_check #(
	parameter int MAX_LEN = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	opc_sym_if.sink   sym,
	opc_res_if.source res
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int HALF_W = LEN_W - 1;
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_ISSUE = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_WRD   = 3'd5;
	localparam logic [2:0] ST_WCMP  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	localparam logic [2:0] OP_RP = 3'd0;
	localparam logic [2:0] OP_FT = 3'd1;
	localparam logic [2:0] OP_FH = 3'd2;
	localparam logic [2:0] OP_SE = 3'd3;
	localparam logic [2:0] OP_LD = 3'd4;
	localparam logic [2:0] OP_RS = 3'd5;
	localparam logic [2:0] OP_SO = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        op_q;
	logic [LEN_W-1:0]  len_q;
	logic [6:0]        fh_q, sh_q, rp_q, t_q;
	logic [7:0]        c_q;
	logic [ADDR_W-1:0] ra_q, rb_q;
	logic [HALF_W-1:0] j_q;
	logic              pal_q, ovf_q;
	logic              res_vld_q, res_pal_q, res_ovf_q;

	logic              acc;
	logic              full;
	logic [LEN_W-1:0]  len_e, len_n;
	logic [HALF_W-1:0] half_n, half, j_nx;
	logic [7:0]        rd_a, rd_b;
	opc_pkg::mod_req_t mu_req;
	logic              mu_done;
	logic [6:0]        mu_res;

	assign sym.ready = (state_q == ST_IDLE);
	assign acc       = sym.valid && sym.ready;
	assign full      = !sym.start_req && (len_q == LEN_W'(MAX_LEN));
	assign len_e     = sym.start_req ? '0 : len_q;
	assign len_n     = len_e + 1'b1;
	assign half_n    = len_n[LEN_W-1:1];
	assign half      = len_q[LEN_W-1:1];
	assign j_nx      = j_q + 1'b1;

	opc_char_store #(
		.DEPTH  (MAX_LEN),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (acc && !full),
		.wa   (ADDR_W'(len_e)),
		.wd   (sym.symbol),
		.ra   (ra_q),
		.rb   (rb_q),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	always_comb begin
		mu_req    = '0;
		mu_req.go = (state_q == ST_ISSUE);
		case (op_q) inside
			OP_RP: begin
				mu_req.a = rp_q;
				mu_req.b = opc_pkg::RADIX_RED;
			end
			OP_FT, OP_LD: begin
				mu_req.a = rp_q;
				mu_req.b = rd_a;
			end
			OP_FH: begin
				mu_req.a = fh_q;
				mu_req.b = 8'd1;
				mu_req.c = {1'b0, t_q};
			end
			OP_SE: begin
				mu_req.a = sh_q;
				mu_req.b = opc_pkg::RADIX_RED;
				mu_req.c = c_q;
			end
			OP_RS: begin
				mu_req.a = sh_q;
				mu_req.b = 8'd1;
				mu_req.c = opc_pkg::MOD - {1'b0, t_q};
			end
			OP_SO: begin
				mu_req.a = t_q;
				mu_req.b = opc_pkg::RADIX_RED;
				mu_req.c = c_q;
			end
			default: mu_req.a = '0;
		endcase
	end

	opc_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mu_req),
		.done   (mu_done),
		.res    (mu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_RP;
			len_q     <= '0;
			fh_q      <= '0;
			sh_q      <= '0;
			rp_q      <= 7'd1;
			res_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!res_vld_q || res.ready)) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (full) begin
							state_q <= ST_FIN;
						end else begin
							len_q <= len_n;
							if (sym.start_req) begin
								fh_q <= '0;
								sh_q <= '0;
								rp_q <= 7'd1;
							end
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					if (half == '0) begin
						state_q <= ST_CHECK;
					end else if (!len_q[0]) begin
						op_q    <= (half > HALF_W'(1)) ? OP_RP : OP_FT;
						state_q <= ST_ISSUE;
					end else begin
						op_q    <= OP_LD;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mu_done) begin
						unique case (op_q) inside
							OP_RP: begin
								rp_q    <= mu_res;
								op_q    <= OP_FT;
								state_q <= ST_ISSUE;
							end
							OP_FH: begin
								fh_q    <= mu_res;
								op_q    <= OP_SE;
								state_q <= ST_ISSUE;
							end
							OP_FT: begin
								op_q    <= OP_FH;
								state_q <= ST_ISSUE;
							end
							OP_LD: begin
								op_q    <= OP_RS;
								state_q <= ST_ISSUE;
							end
							OP_RS: begin
								op_q    <= OP_SO;
								state_q <= ST_ISSUE;
							end
							OP_SE, OP_SO: begin
								sh_q    <= mu_res;
								state_q <= ST_CHECK;
							end
							default: state_q <= ST_CHECK;
						endcase
					end
				end
				ST_CHECK: begin
					if (fh_q != sh_q || half == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_WRD: state_q <= ST_WCMP;
				ST_WCMP: begin
					if (rd_a != rd_b || j_nx == half) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_FIN: begin
					if (!res_vld_q || res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					c_q   <= sym.symbol;
					pal_q <= 1'b0;
					ovf_q <= full;
					ra_q  <= len_n[0] ? ADDR_W'(half_n) : ADDR_W'(half_n - 1'b1);
				end
			end
			ST_WAIT: begin
				if (mu_done && (op_q == OP_FT || op_q == OP_LD || op_q == OP_RS)) begin
					t_q <= mu_res;
				end
			end
			ST_CHECK: begin
				pal_q <= (fh_q == sh_q) && (half == '0);
				j_q   <= '0;
				ra_q  <= '0;
				rb_q  <= ADDR_W'(len_q - 1'b1);
			end
			ST_WCMP: begin
				pal_q <= (rd_a == rd_b) && (j_nx == half);
				j_q   <= j_nx;
				ra_q  <= ADDR_W'(j_nx);
				rb_q  <= rb_q - 1'b1;
			end
			ST_FIN: begin
				if (!res_vld_q || res.ready) begin
					res_pal_q <= pal_q;
					res_ovf_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid         = res_vld_q;
	assign res.is_palindrome = res_pal_q;
	assign res.overflow      = res_ovf_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("prefix length beyond buffer depth");

	a_ovf_not_pal: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.overflow && res.is_palindrome))
		else $error("dropped byte reported as palindrome");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mu_done |-> state_q == ST_WAIT)
		else $error("mod unit result outside wait state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !sym.ready)
		else $error("ready did not drop after accepted request");

endmodule

// ===== tb/tb_online_prefix_palindrome_check.sv =====
// Testbench for online_prefix_palindrome_check: directed, buffer-full and random string requests.
// A local hash-and-mirror predictor checks every result, under several idle and stall phases.
// Depends on opc_sym_if, opc_res_if and online_prefix_palindrome_check.
module tb_online_prefix_palindrome_check;

	localparam int MAX_LEN        = 1024;
	localparam int HASH_MOD       = 103;
	localparam int HASH_RADIX     = 256;
	localparam int MAX_TEXT       = 160;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 1200;

	typedef struct packed {
		logic is_pal;
		logic ovf;
	} verdict_t;

	typedef enum int {
		TEXT_MIRROR,
		TEXT_NEAR_MIRROR,
		TEXT_HASH_TWIN,
		TEXT_TWO_SYMBOLS,
		TEXT_NOISE
	} text_kind_e;

	logic clk;
	logic arst_n;

	opc_sym_if sym_if();
	opc_res_if res_if();

	online_prefix_palindrome_check #(
		.MAX_LEN(MAX_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sym   (sym_if),
		.res   (res_if)
	);

	verdict_t    verdict_q[$];
	logic [7:0]  prefix_chars[MAX_LEN];
	int unsigned prefix_len;
	int unsigned rev_half_hash;
	int unsigned tail_half_hash;
	int unsigned radix_pow;

	int fail_count;
	int result_count;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mirrors the block: hashes over both halves, mirror walk on a hash hit
	function automatic verdict_t predict_verdict(logic [7:0] sym, logic start);
		int unsigned n;
		int unsigned half;
		int unsigned lead;
		int unsigned rest;
		int unsigned j;
		verdict_t v;
		if (start) begin
			prefix_len     = 0;
			rev_half_hash  = 0;
			tail_half_hash = 0;
			radix_pow      = 1;
		end
		v.is_pal = 1'b0;
		v.ovf    = 1'b0;
		if (prefix_len >= MAX_LEN) begin
			v.ovf = 1'b1;
			return v;
		end
		prefix_chars[prefix_len] = sym;
		n    = prefix_len + 1;
		half = n / 2;
		if (n % 2 == 0) begin
			if (half >= 2)
				radix_pow = (radix_pow * HASH_RADIX) % HASH_MOD;
			rev_half_hash = (rev_half_hash
				+ (radix_pow * prefix_chars[half - 1]) % HASH_MOD) % HASH_MOD;
			tail_half_hash = (tail_half_hash * HASH_RADIX + sym) % HASH_MOD;
		end else if (half >= 1) begin
			lead = (radix_pow * prefix_chars[half]) % HASH_MOD;
			rest = (tail_half_hash + HASH_MOD - lead) % HASH_MOD;
			tail_half_hash = (rest * HASH_RADIX + sym) % HASH_MOD;
		end
		prefix_len = n;
		if (rev_half_hash == tail_half_hash) begin
			v.is_pal = 1'b1;
			for (j = 0; j < n / 2; j++)
				if (prefix_chars[j] != prefix_chars[n - 1 - j])
					v.is_pal = 1'b0;
		end
		return v;
	endfunction

	task automatic report_error(string msg);
		if (fail_count < 40)
			$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic send_symbol(logic [7:0] sym, logic start);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sym_if.valid = 1'b0;
			@(negedge clk);
		end
		sym_if.valid     = 1'b1;
		sym_if.symbol    = sym;
		sym_if.start_req = start;
		do
			@(posedge clk);
		while (!sym_if.ready);
		verdict_q.push_back(predict_verdict(sym, start));
	endtask

	// receiver side: stall at the phase's rate
	always @(negedge clk)
		res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (res_if.valid && res_if.ready) begin
			if (verdict_q.size() == 0) begin
				report_error($sformatf("result %0d (pal %b ovf %b) with no request pending",
					result_count, res_if.is_palindrome, res_if.overflow));
			end else begin
				want = verdict_q.pop_front();
				if (res_if.is_palindrome !== want.is_pal)
					report_error($sformatf("result %0d is_palindrome %b, expected %b",
						result_count, res_if.is_palindrome, want.is_pal));
				if (res_if.overflow !== want.ovf)
					report_error($sformatf("result %0d overflow %b, expected %b",
						result_count, res_if.overflow, want.ovf));
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("online_prefix_palindrome_check test failed");
				$finish;
			end
		end
	end

	task automatic test_directed();
		// no start after reset: the first byte opens a string anyway
		send_symbol(8'hFF, 1'b0);
		send_symbol(8'hFF, 1'b0);
		send_symbol(8'h00, 1'b1);
		send_symbol(8'hFF, 1'b0);
		send_symbol(8'h00, 1'b0);
		// hash hit on an even length without a palindrome
		send_symbol(8'h00, 1'b1);
		send_symbol(8'd103, 1'b0);
		send_symbol(8'd152, 1'b1);
		send_symbol(8'd255, 1'b0);
		// hash hit on an odd length without a palindrome
		send_symbol(8'd1, 1'b1);
		send_symbol(8'd77, 1'b0);
		send_symbol(8'd104, 1'b0);
		// odd palindrome, then a start in the middle of a string
		send_symbol(8'hAA, 1'b1);
		send_symbol(8'h55, 1'b0);
		send_symbol(8'h0F, 1'b0);
		send_symbol(8'h55, 1'b0);
		send_symbol(8'hAA, 1'b0);
		send_symbol(8'hF0, 1'b1);
		send_symbol(8'hF0, 1'b0);
		send_symbol(8'hF0, 1'b0);
	endtask

	task automatic test_buffer_full();
		int i;
		send_symbol(8'($urandom), 1'b1);
		for (i = 1; i < MAX_LEN; i++)
			send_symbol(8'($urandom), 1'b0);
		// dropped bytes until a start request
		for (i = 0; i < 6; i++)
			send_symbol(8'($urandom), 1'b0);
		send_symbol(8'h00, 1'b1);
		send_symbol(8'h00, 1'b0);
	endtask

	task automatic test_random_strings(int count);
		logic [7:0] text[MAX_TEXT];
		text_kind_e kind;
		logic [7:0] sym_a;
		logic [7:0] sym_b;
		int         sent;
		int         len;
		int         i;
		int         p;
		logic       start;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(99) < 95) ? $urandom_range(1, 24)
				: $urandom_range(25, MAX_TEXT);
			kind  = text_kind_e'($urandom_range(TEXT_NOISE, TEXT_MIRROR));
			sym_a = 8'($urandom);
			sym_b = 8'($urandom);
			for (i = 0; i < len; i++) begin
				if (kind == TEXT_NOISE)
					text[i] = 8'($urandom);
				else if (kind == TEXT_TWO_SYMBOLS)
					text[i] = $urandom_range(1) ? sym_a : sym_b;
				else if (i < (len + 1) / 2)
					text[i] = 8'($urandom);
				else
					text[i] = text[len - 1 - i];
			end
			p = $urandom_range(len - 1);
			if (kind == TEXT_NEAR_MIRROR)
				text[p] = 8'($urandom);
			// same residue mod 103, different byte
			if (kind == TEXT_HASH_TWIN)
				text[p] = (text[p] >= 8'd103) ? text[p] - 8'd103
					: (text[p] <= 8'd152) ? text[p] + 8'd103 : text[p];
			for (i = 0; i < len; i++) begin
				if (i == 0)
					start = ($urandom_range(99) >= 5) || (prefix_len + len > MAX_LEN);
				else
					start = ($urandom_range(99) < 3);
				send_symbol(text[i], start);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		sym_if.valid     = 1'b0;
		sym_if.symbol    = 8'h00;
		sym_if.start_req = 1'b0;
		res_if.ready     = 1'b0;
		fail_count       = 0;
		result_count     = 0;
		idle_cycles      = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		prefix_len       = 0;
		rev_half_hash    = 0;
		tail_half_hash   = 0;
		radix_pow        = 1;
		foreach (prefix_chars[k])
			prefix_chars[k] = 8'h00;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_strings(40);

		send_idle_pct  = 78;
		recv_stall_pct = 0;
		test_random_strings(40);

		send_idle_pct  = 0;
		recv_stall_pct = 78;
		test_random_strings(40);

		send_idle_pct  = 8;
		recv_stall_pct = 8;
		test_buffer_full();
		test_random_strings(40);

		@(negedge clk);
		sym_if.valid = 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("online_prefix_palindrome_check test passed");
		else
			$display("online_prefix_palindrome_check test failed");
		$finish;
	end

endmodule
